// ===== hw/rtl/rps_pkg.sv =====
// rps_pkg: shared widths, register indexes and constants of the radiometer pixel screen
// used by rps_sqrt, radiometer_pixel_screen_param_unit and rps_chk
package rps_pkg;

  localparam int TempW   = 16;
  localparam int OpW     = TempW + 1;
  localparam int ProdW   = 2 * OpW;
  localparam int DiffW   = 30;
  localparam int RadW    = DiffW + 8;
  localparam int RootW   = RadW / 2;
  localparam int CountW  = 20;
  localparam int LimW    = 15;
  localparam int RatioW  = 10;
  localparam int CfgIdxW = 3;
  localparam int TotalW  = 20;

  localparam logic [OpW-1:0] RatioScale = OpW'(1000);

  localparam logic [CfgIdxW-1:0] CfgH37Min   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgV37Min   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTempMax  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRatio37  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRatio22  = 3'd4;

  localparam logic [LimW-1:0]   H37MinRst  = 15'd1000;
  localparam logic [LimW-1:0]   V37MinRst  = 15'd1500;
  localparam logic [LimW-1:0]   TempMaxRst = 15'd2950;
  localparam logic [RatioW-1:0] Ratio37Rst = 10'd50;
  localparam logic [RatioW-1:0] Ratio22Rst = 10'd45;

endpackage

// ===== hw/rtl/rps_sqrt.sv =====
// rps_sqrt: bit-serial integer square root, one result bit per cycle
// depends on rps_pkg
module rps_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rps_pkg::RadW-1:0] rad_i,
  output logic                     done_o,
  output logic [rps_pkg::RootW-1:0] root_o
);

  localparam int RemW = rps_pkg::RootW + 3;
  localparam int ItW  = $clog2(rps_pkg::RootW);

  logic                      busy_q;
  logic                      done_q;
  logic [ItW-1:0]            it_q;
  logic [rps_pkg::RadW-1:0]  rad_q;
  logic [RemW-1:0]           rem_q;
  logic [rps_pkg::RootW-1:0] root_q;
  logic [RemW-1:0]           rem_sh;
  logic [RemW-1:0]           trial;
  logic                      fits;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[rps_pkg::RadW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
      end else if (busy_q) begin
        if (it_q == ItW'(rps_pkg::RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        it_q <= it_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[rps_pkg::RadW-3:0], 2'b00};
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[rps_pkg::RootW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== hw/rtl/radiometer_pixel_screen_param_unit.sv =====
// radiometer_pixel_screen_param_unit: pixel screens, exact ratio tests and scaled root
// depends on rps_pkg and rps_sqrt
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata v19,v22,v37,h37; tuser first_pixel
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata root_q4,reject_total; tuser rejected
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// an item runs five products through the one 17x17 multiplier; an item that passes
// then goes through the bit-serial root unit, while a rejected one skips it
// s_axis_tready is high only in idle; a waiting result stalls the next one, not the input
// reset restores the register defaults and clears the reject count
module radiometer_pixel_screen_param_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,  // v19, v22, v37, h37
  input  logic                        s_axis_tuser,  // first_pixel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [39:0]                 m_axis_tdata,  // root_q4, reject_total, zero pad
  output logic                        m_axis_tuser,  // rejected
  input  logic                        cfg_we_i,
  input  logic [rps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rps_pkg::LimW-1:0]    cfg_wdata_i
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StR22N  = 8'b0000_0010,
    StR22D  = 8'b0000_0100,
    StR37N  = 8'b0000_1000,
    StR37D  = 8'b0001_0000,
    StDiff  = 8'b0010_0000,
    StRoot  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  localparam int TempW = rps_pkg::TempW;
  localparam int OpW   = rps_pkg::OpW;
  localparam int ProdW = rps_pkg::ProdW;

  state_e state_q, state_d;

  logic [rps_pkg::LimW-1:0]   h37_min_q, v37_min_q, temp_max_q;
  logic [rps_pkg::RatioW-1:0] ratio37_q, ratio22_q;

  logic signed [TempW-1:0] v19_q, v22_q, v37_q, h37_q;
  logic                    rej_q;
  logic signed [ProdW-1:0] lhs_q;
  logic [rps_pkg::CountW-1:0] cnt_q;
  logic [rps_pkg::CountW-1:0] cnt_inc;

  logic                        out_valid_q;
  logic                        out_rej_q;
  logic [rps_pkg::RootW-1:0]   out_root_q;
  logic [rps_pkg::TotalW-1:0]  out_total_q;

  logic signed [OpW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic                    exceeds;
  logic                    window_rej;
  logic                    in_acc;
  logic                    out_free;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [rps_pkg::RootW-1:0] sqrt_root;

  logic signed [OpW-1:0] v19_x, v22_x, v37_x, h37_x;

  assign v19_x = OpW'(v19_q);
  assign v22_x = OpW'(v22_q);
  assign v37_x = OpW'(v37_q);
  assign h37_x = OpW'(h37_q);

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StR22N: begin
        mul_a = v22_x - v19_x;
        mul_b = rps_pkg::RatioScale;
      end
      StR22D: begin
        mul_a = $signed(OpW'(ratio22_q));
        mul_b = v22_x + v19_x;
      end
      StR37N: begin
        mul_a = v37_x - v19_x;
        mul_b = rps_pkg::RatioScale;
      end
      StR37D: begin
        mul_a = $signed(OpW'(ratio37_q));
        mul_b = v37_x + v19_x;
      end
      StDiff: begin
        mul_a = v37_x - h37_x;
        mul_b = v37_x + h37_x;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // sense flips with a negative denominator; a zero one reduces to num > 0
  assign exceeds = mul_b[OpW-1] ? (lhs_q < prod) : (lhs_q > prod);

  assign window_rej = (h37_q > v37_q)
                   || (h37_q < $signed({1'b0, h37_min_q}))
                   || (v37_q < $signed({1'b0, v37_min_q}))
                   || (h37_q > $signed({1'b0, temp_max_q}))
                   || (v37_q > $signed({1'b0, temp_max_q}));

  assign sqrt_start = (state_q == StDiff) && !rej_q;
  assign cnt_inc    = (rej_q && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;

  rps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ({prod[rps_pkg::DiffW-1:0], 8'h00}),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StR22N;
      StR22N: state_d = StR22D;
      StR22D: state_d = StR37N;
      StR37N: state_d = StR37D;
      StR37D: state_d = StDiff;
      StDiff: state_d = rej_q ? StDone : StRoot;
      StRoot: if (sqrt_done) state_d = StDone;
      StDone: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      h37_min_q   <= rps_pkg::H37MinRst;
      v37_min_q   <= rps_pkg::V37MinRst;
      temp_max_q  <= rps_pkg::TempMaxRst;
      ratio37_q   <= rps_pkg::Ratio37Rst;
      ratio22_q   <= rps_pkg::Ratio22Rst;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rps_pkg::CfgH37Min:  h37_min_q  <= cfg_wdata_i;
          rps_pkg::CfgV37Min:  v37_min_q  <= cfg_wdata_i;
          rps_pkg::CfgTempMax: temp_max_q <= cfg_wdata_i;
          rps_pkg::CfgRatio37: ratio37_q  <= cfg_wdata_i[rps_pkg::RatioW-1:0];
          rps_pkg::CfgRatio22: ratio22_q  <= cfg_wdata_i[rps_pkg::RatioW-1:0];
          default: ;
        endcase
      end
      if (in_acc && s_axis_tuser) begin
        cnt_q <= '0;
      end else if ((state_q == StDone) && out_free) begin
        cnt_q <= cnt_inc;
      end
      if ((state_q == StDone) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v19_q <= s_axis_tdata[15:0];
      v22_q <= s_axis_tdata[31:16];
      v37_q <= s_axis_tdata[47:32];
      h37_q <= s_axis_tdata[63:48];
    end
    unique case (state_q)
      StR22N: begin
        rej_q <= window_rej;
        lhs_q <= prod;
      end
      StR22D: rej_q <= rej_q || exceeds;
      StR37N: lhs_q <= prod;
      StR37D: rej_q <= rej_q || exceeds;
      default: ;
    endcase
    if ((state_q == StDone) && out_free) begin
      out_rej_q   <= rej_q;
      out_root_q  <= rej_q ? '0 : sqrt_root;
      out_total_q <= cnt_inc[rps_pkg::TotalW-1:0];
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_rej_q;
  assign m_axis_tdata  = {1'b0, out_total_q, out_root_q};

endmodule

// ===== hw/rtl/rps_chk.sv =====
// rps_chk: port-level checks on the radiometer pixel screen, bound to the top level
// depends on rps_pkg
module rps_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after an accepted item");

  // a result appears only as an item finishes
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised while idle");

  // rejected items carry no root
  a_reject_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[rps_pkg::RootW-1:0] == '0)
    else $error("rejected item with nonzero root");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind radiometer_pixel_screen_param_unit rps_chk u_rps_chk (.*);
